### hdl/lpbm_pkg.sv
`timescale 1ns / 1ps
package lpbm_pkg;

  localparam int DefNumPages   = 1024;
  localparam int DefNumQueues  = 8;
  localparam int DefLengthBits = 16;

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_FREE    = 3'd1,
    CMD_ENQUEUE = 3'd2,
    CMD_DEQUEUE = 3'd3,
    CMD_DELETE  = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_IGNORED  = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  queue_id;
    logic [9:0]  page_index;
    logic [15:0] length;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  page_out;
    logic [15:0] length_out;
    logic [10:0] free_pages;
    logic [10:0] queue_count;
  } out_item_t;

endpackage

### hdl/linked_page_buffer_manager_core.sv
`timescale 1ns / 1ps
// Linked page buffer manager.
// A pool of pages shares one next-link memory, from which a LIFO free list and
// a set of FIFO queues are built. A command item is taken on in_item when
// start is high and busy is low; busy then stays high until the result item
// has been shown.
// Each result is presented on out_item for exactly one cycle with out_valid
// high; the receiver must take it then, as it cannot stall the block.
// Alloc, free, enqueue and dequeue run through S_READ, which reads the link
// memory, S_DEC, which registers the decision and writes it back, and S_OUT,
// where an enqueue links the old tail and the result strobe is raised; a new
// item can be taken while the strobe is high.
// Delete walks the queue from the head, one link per pass through S_WALKDEC
// and S_WALK; a page found behind the head also passes S_DELWR to relink its
// predecessor, and a page that is not in the queue ends the walk at its end.
// After reset the block first runs a clearing pass that builds the free
// chain, one page per cycle over all NUM_PAGES pages, with busy high meanwhile.
// Page lengths and allocated marks live in a second memory and are written
// during the same pass.
module linked_page_buffer_manager_core
  import lpbm_pkg::*;
#(
  parameter int NUM_PAGES   = DefNumPages,
  parameter int NUM_QUEUES  = DefNumQueues,
  parameter int LENGTH_BITS = DefLengthBits
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int PW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CW = $clog2(NUM_PAGES + 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_READ, S_DEC, S_WALK, S_WALKDEC, S_DELWR, S_OUT
  } state_t;

  state_t state_r;
  logic [PW-1:0] link_mem [NUM_PAGES];
  logic [LENGTH_BITS:0] data_mem [NUM_PAGES];
  logic [PW-1:0] qhead [NUM_QUEUES];
  logic [PW-1:0] qtail [NUM_QUEUES];
  logic [CW-1:0] qcnt_r [NUM_QUEUES];

  logic [PW-1:0] link_rd_r;
  logic [LENGTH_BITS:0] data_rd_r;
  logic [PW-1:0] init_r, free_head_r, cur_r, prev_r;
  logic [CW-1:0] free_total_r, k_r;
  logic [2:0] cmd_r;
  logic [QW-1:0] q_r;
  logic [15:0] pg_r;
  logic pg_ok_r;
  logic [LENGTH_BITS-1:0] len_r;
  logic [1:0] st_r;
  logic [9:0] pout_r;
  logic [15:0] lout_r;
  logic out_valid_r;

  logic [PW-1:0] rd_addr;
  logic lwe, dwe;
  logic [PW-1:0] lwa, dwa, lwd;
  logic [LENGTH_BITS:0] dwd;
  logic [PW-1:0] p;
  logic [QW-1:0] q_in;

  assign p = pg_r[PW-1:0];
  assign q_in = QW'(32'(in_item.queue_id) % NUM_QUEUES);

  always_comb begin
    rd_addr = '0;
    case (state_r)
      S_IDLE: begin
        rd_addr = in_item.page_index[PW-1:0];
        if (in_item.command == CMD_ALLOC) begin
          rd_addr = free_head_r;
        end else if (in_item.command == CMD_DEQUEUE || in_item.command == CMD_DELETE) begin
          rd_addr = qhead[q_in];
        end
      end
      S_READ, S_DEC: begin
        rd_addr = p;
        if (cmd_r == CMD_ALLOC) begin
          rd_addr = free_head_r;
        end else if (cmd_r == CMD_DEQUEUE || cmd_r == CMD_DELETE) begin
          rd_addr = qhead[q_r];
        end
      end
      S_WALKDEC: rd_addr = (pg_ok_r && cur_r == p) ? cur_r : link_rd_r;
      default: rd_addr = cur_r;
    endcase
  end

  always_comb begin
    lwe = 1'b0;
    lwa = '0;
    lwd = '0;
    dwe = 1'b0;
    dwa = '0;
    dwd = '0;
    if (state_r == S_INIT) begin
      lwe = 1'b1;
      lwa = init_r;
      lwd = (32'(init_r) + 1 < NUM_PAGES) ? PW'(32'(init_r) + 1) : '0;
      dwe = 1'b1;
      dwa = init_r;
    end else if (state_r == S_DEC) begin
      case (cmd_r)
        CMD_ALLOC: if (free_total_r != '0) begin
          lwe = 1'b1; lwa = free_head_r;
          dwe = 1'b1; dwa = free_head_r; dwd = {1'b1, {LENGTH_BITS{1'b0}}};
        end
        CMD_FREE: if (pg_ok_r && data_rd_r[LENGTH_BITS]) begin
          lwe = 1'b1; lwa = p; lwd = (free_total_r != '0) ? free_head_r : '0;
          dwe = 1'b1; dwa = p;
        end
        CMD_ENQUEUE: if (pg_ok_r && 32'(qcnt_r[q_r]) < NUM_PAGES) begin
          dwe = 1'b1; dwa = p; dwd = {data_rd_r[LENGTH_BITS], len_r};
          lwe = 1'b1; lwa = p;
        end
        default: ;
      endcase
    end else if (state_r == S_OUT && cmd_r == CMD_ENQUEUE && st_r == ST_DONE
                 && qcnt_r[q_r] != CW'(1)) begin
      lwe = 1'b1; lwa = qtail[q_r]; lwd = p;
    end else if (state_r == S_DELWR) begin
      lwe = 1'b1; lwa = prev_r;
      lwd = (cur_r == qtail[q_r]) ? '0 : link_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (lwe) begin
      link_mem[lwa] <= lwd;
    end
    if (dwe) begin
      data_mem[dwa] <= dwd;
    end
    link_rd_r <= link_mem[rd_addr];
    data_rd_r <= data_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      init_r <= '0;
      free_head_r <= '0;
      free_total_r <= CW'(NUM_PAGES);
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        qcnt_r[i] <= '0;
      end
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_INIT: begin
          init_r <= init_r + PW'(1);
          if (32'(init_r) == NUM_PAGES - 1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: if (start) begin
          cmd_r <= in_item.command;
          q_r <= q_in;
          pg_r <= {6'd0, in_item.page_index};
          pg_ok_r <= 32'(in_item.page_index) < NUM_PAGES;
          len_r <= LENGTH_BITS'(in_item.length);
          st_r <= ST_DONE;
          pout_r <= '0;
          lout_r <= '0;
          state_r <= S_READ;
        end
        S_READ: state_r <= S_DEC;
        S_DEC: begin
          state_r <= S_OUT;
          case (cmd_r)
            CMD_ALLOC: if (free_total_r == '0) begin
              st_r <= ST_EMPTY;
            end else begin
              free_head_r <= link_rd_r;
              free_total_r <= free_total_r - CW'(1);
              pout_r <= 10'(free_head_r);
            end
            CMD_FREE: if (!pg_ok_r || !data_rd_r[LENGTH_BITS]) begin
              st_r <= ST_IGNORED;
            end else begin
              free_head_r <= p;
              free_total_r <= free_total_r + CW'(1);
            end
            CMD_ENQUEUE: if (!pg_ok_r || 32'(qcnt_r[q_r]) >= NUM_PAGES) begin
              st_r <= ST_NOTFOUND;
            end else begin
              if (qcnt_r[q_r] == '0) begin
                qhead[q_r] <= p;
              end
              qcnt_r[q_r] <= qcnt_r[q_r] + CW'(1);
            end
            CMD_DEQUEUE: if (qcnt_r[q_r] == '0) begin
              st_r <= ST_EMPTY;
            end else begin
              qhead[q_r] <= link_rd_r;
              pout_r <= 10'(qhead[q_r]);
              lout_r <= 16'(data_rd_r[LENGTH_BITS-1:0]);
              qcnt_r[q_r] <= qcnt_r[q_r] - CW'(1);
            end
            CMD_DELETE: if (qcnt_r[q_r] == '0) begin
              st_r <= ST_EMPTY;
            end else begin
              cur_r <= qhead[q_r];
              k_r <= '0;
              state_r <= S_WALKDEC;
            end
            default: ;
          endcase
        end
        S_WALKDEC: begin
          if (k_r == qcnt_r[q_r]) begin
            st_r <= ST_NOTFOUND;
            state_r <= S_OUT;
          end else if (pg_ok_r && cur_r == p) begin
            pout_r <= 10'(cur_r);
            qcnt_r[q_r] <= qcnt_r[q_r] - CW'(1);
            if (k_r == '0) begin
              qhead[q_r] <= link_rd_r;
              state_r <= S_OUT;
            end else begin
              state_r <= S_DELWR;
            end
          end else begin
            prev_r <= cur_r;
            cur_r <= link_rd_r;
            k_r <= k_r + CW'(1);
            state_r <= S_WALK;
          end
        end
        S_WALK: state_r <= S_WALKDEC;
        S_DELWR: begin
          if (cur_r == qtail[q_r]) begin
            qtail[q_r] <= prev_r;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (cmd_r == CMD_ENQUEUE && st_r == ST_DONE) begin
            qtail[q_r] <= p;
          end
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item.status = st_r;
  assign out_item.page_out = pout_r;
  assign out_item.length_out = lout_r;
  assign out_item.free_pages = 11'(free_total_r);
  assign out_item.queue_count = 11'(qcnt_r[q_r]);

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(free_total_r) <= NUM_PAGES) else $error("free count beyond pool");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe lasted two cycles");
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("item accepted but block not busy");

endmodule
